FILE: rtl/core/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants for the keyframe track sampler
// Field widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int MaxKeysDef = 64;
  localparam int TimeW      = 17;
  localparam int ValW       = 32;
  localparam int NumComp    = 4;
  localparam int DeltaW     = TimeW + 1;           // signed time difference
  localparam int ProdW      = ValW + 1 + DeltaW;   // signed product
  localparam int MagW       = ProdW - 1;           // product magnitude
  localparam int SumW       = ProdW + 1;

  localparam logic CmdAppend = 1'b0;
  localparam logic CmdSample = 1'b1;

  localparam logic ModeStep   = 1'b0;
  localparam logic ModeLinear = 1'b1;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;
  localparam logic [1:0] StatSat   = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StScanChk,
    StLoadC,
    StLoadN,
    StDecide,
    StMul,
    StDivStart,
    StDivWait
  } state_e;

endpackage

FILE: rtl/core/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; a start is taken only when not busy.
// ----------------------------------------------------------------------------
module kts_div #(
  parameter int NUM_W = kts_pkg::MagW,
  parameter int DEN_W = kts_pkg::TimeW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0 || $past(busy_q) == 1'b0) else $error("divider count");
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q) else $error("divider did not start");
`endif

endmodule

FILE: rtl/core/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler: keyframe table with step and linear sampling
// Appends keyframes into on-chip memories and samples them at a query time.
// ----------------------------------------------------------------------------
// An append item returns zeros (status 2 if the table is full). A sample
// item scans the key time memory, a scan state and a check state per key,
// until the first key later than the query or the last key, then reads the
// selected key and its successor. Step mode, the last key and a non-positive
// time gap finish there; an empty table returns status 1 with no scan. Linear
// mode then runs each of the four components through one multiplier and a
// shared serial divider of kts_pkg::MagW quotient bits. A new item is taken
// only when the sequencer is idle and the result register is empty. Memories
// need no clearing pass; entries at or above the key count may be read, but
// their values are never used.
module keyframe_track_sampler #(
  parameter int MAX_KEYS = kts_pkg::MaxKeysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [16:0] time_point_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic signed [31:0] value_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_w_o,
  output logic [1:0]  status_o
);

  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW   = $clog2(MAX_KEYS + 1);
  localparam int TW   = kts_pkg::TimeW;
  localparam int VW   = kts_pkg::ValW;
  localparam int NC   = kts_pkg::NumComp;
  localparam int RowW = NC * VW;

  // key memories: one row per key
  logic [TW-1:0]   tmem [MAX_KEYS];
  logic [RowW-1:0] vmem [MAX_KEYS];
  logic [TW-1:0]   trd_q;
  logic [RowW-1:0] vrd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;

  kts_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q;
  logic [AW-1:0] idx_q, c_q;
  logic [TW-1:0] t_q, tc_q;
  logic          mode_q;
  logic [RowW-1:0] vc_q, vn_q;
  logic signed [kts_pkg::DeltaW-1:0] d_q, dt;
  logic [TW-1:0] dt_q;
  logic signed [kts_pkg::ProdW-1:0] prod_q;
  logic [1:0] comp_q;
  logic signed [VW-1:0] res_q [NC];
  logic [1:0] stat_q;
  logic       sat_q, out_valid_q;

  logic in_acc, has_next, last_key, brk;
  logic signed [VW-1:0] vc_sel, vn_sel;
  logic signed [VW:0]   diff;
  logic                 div_start, div_busy, div_done;
  logic [kts_pkg::MagW-1:0] div_quot;
  logic [kts_pkg::MagW-1:0] mag;
  logic signed [kts_pkg::ProdW-1:0] q_s;
  logic signed [kts_pkg::SumW-1:0]  sum;
  logic signed [VW-1:0] sat_val;
  logic                 sat_hit;

  assign in_ready_o = (state_q == kts_pkg::StIdle) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && (command_i == kts_pkg::CmdAppend) &&
                      (count_q < CW'(MAX_KEYS));

  assign has_next = (CW'(c_q) + CW'(1)) < count_q;
  assign last_key = (CW'(idx_q) + CW'(1)) == count_q;
  assign brk      = t_q < trd_q;

  assign vc_sel = vc_q[comp_q*VW +: VW];
  assign vn_sel = vn_q[comp_q*VW +: VW];
  assign diff   = {vn_sel[VW-1], vn_sel} - {vc_sel[VW-1], vc_sel};
  assign dt     = $signed({1'b0, trd_q}) - $signed({1'b0, tc_q});

  // magnitude of the product and signed quotient (truncated toward zero)
  assign mag = prod_q[kts_pkg::ProdW-1] ? kts_pkg::MagW'(-prod_q)
                                        : kts_pkg::MagW'(prod_q);
  assign q_s = prod_q[kts_pkg::ProdW-1] ? -$signed({1'b0, div_quot})
                                        : $signed({1'b0, div_quot});
  assign sum = kts_pkg::SumW'(vc_sel) + kts_pkg::SumW'(q_s);

  always_comb begin
    sat_hit = 1'b1;
    if (sum > kts_pkg::SumW'(32'sh7fff_ffff)) begin
      sat_val = 32'sh7fff_ffff;
    end else if (sum < -kts_pkg::SumW'(64'sh8000_0000)) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = sum[VW-1:0];
      sat_hit = 1'b0;
    end
  end

  kts_div #(
    .NUM_W(kts_pkg::MagW),
    .DEN_W(TW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mag),
    .den_i  (dt_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // memory ports: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tmem[AW'(count_q)] <= time_point_i;
      vmem[AW'(count_q)] <= {value_w_i, value_z_i, value_y_i, value_x_i};
    end
    trd_q <= tmem[rd_addr];
    vrd_q <= vmem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    rd_addr   = idx_q;
    div_start = 1'b0;
    unique case (state_q)
      kts_pkg::StIdle: begin
        if (in_acc && command_i == kts_pkg::CmdSample && count_q != '0) begin
          state_d = kts_pkg::StScan;
        end
      end
      kts_pkg::StScan:    state_d = kts_pkg::StScanChk;
      kts_pkg::StScanChk: begin
        state_d = (brk || last_key) ? kts_pkg::StLoadC : kts_pkg::StScan;
      end
      kts_pkg::StLoadC: begin
        rd_addr = c_q;
        state_d = kts_pkg::StLoadN;
      end
      kts_pkg::StLoadN: begin
        rd_addr = c_q + AW'(1);
        state_d = kts_pkg::StDecide;
      end
      kts_pkg::StDecide: begin
        if (mode_q == kts_pkg::ModeLinear && has_next && dt > 0) begin
          state_d = kts_pkg::StMul;
        end else begin
          state_d = kts_pkg::StIdle;
        end
      end
      kts_pkg::StMul:      state_d = kts_pkg::StDivStart;
      kts_pkg::StDivStart: begin
        div_start = 1'b1;
        state_d   = kts_pkg::StDivWait;
      end
      kts_pkg::StDivWait: begin
        if (div_done) begin
          state_d = (comp_q == 2'(NC - 1)) ? kts_pkg::StIdle : kts_pkg::StMul;
        end
      end
      default: state_d = kts_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kts_pkg::StIdle;
      count_q     <= '0;
      mode_q      <= kts_pkg::ModeLinear;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && (command_i == kts_pkg::CmdAppend || count_q == '0)) begin
        out_valid_q <= 1'b1;
      end
      if (state_q != kts_pkg::StIdle && state_d == kts_pkg::StIdle) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      kts_pkg::StIdle: begin
        if (in_acc) begin
          t_q   <= time_point_i;
          idx_q <= '0;
          c_q   <= '0;
          for (int k = 0; k < NC; k++) res_q[k] <= '0;
          if (command_i == kts_pkg::CmdAppend) begin
            stat_q <= (count_q < CW'(MAX_KEYS)) ? kts_pkg::StatOk : kts_pkg::StatFull;
          end else begin
            stat_q <= (count_q == '0) ? kts_pkg::StatEmpty : kts_pkg::StatOk;
          end
        end
      end
      kts_pkg::StScanChk: begin
        if (!brk) begin
          c_q <= idx_q;
          if (!last_key) idx_q <= idx_q + AW'(1);
        end
      end
      kts_pkg::StLoadN: begin
        tc_q <= trd_q;
        vc_q <= vrd_q;
      end
      kts_pkg::StDecide: begin
        vn_q   <= vrd_q;
        dt_q   <= dt[TW-1:0];
        d_q    <= $signed({1'b0, t_q}) - $signed({1'b0, tc_q});
        comp_q <= '0;
        sat_q  <= 1'b0;
        for (int k = 0; k < NC; k++) res_q[k] <= vc_q[k*VW +: VW];
      end
      kts_pkg::StMul: begin
        prod_q <= diff * d_q;
      end
      kts_pkg::StDivWait: begin
        if (div_done) begin
          res_q[comp_q] <= sat_val;
          comp_q        <= comp_q + 2'd1;
          if (sat_hit || sat_q) begin
            sat_q  <= 1'b1;
            stat_q <= kts_pkg::StatSat;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[3];
  assign status_o    = stat_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS)) else $error("key count beyond table");
  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + CW'(1)) else $error("append lost");
  a_no_div_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != kts_pkg::StIdle) |-> !out_valid_q) else $error("result during sample");
`endif

endmodule
